### design/sidta_pkg.sv
// Package for the signed integer to decimal ASCII converter.
// Holds widths, character codes, FSM state type and the converter result struct.
// No dependencies.
package sidta_pkg;

  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned NDIGITS   = 10;                 // decimal digits of 2^32-1
  localparam int unsigned BCD_W     = 4 * NDIGITS;
  localparam int unsigned DIG_IDX_W = $clog2(NDIGITS);
  localparam int unsigned BIT_CNT_W = $clog2(VALUE_W);

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;         // '0'
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;         // '-'

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_DIGIT
  } state_e;

  typedef struct packed {
    logic                 done;   // one-cycle pulse, bcd is final
    logic [DIG_IDX_W-1:0] lead;   // index of the most significant nonzero digit
    logic [BCD_W-1:0]     bcd;
  } dd_res_t;

endpackage

### design/sidta_in_if.sv
// Input channel of the converter: valid/ready plus the signed value.
// Depends on sidta_pkg.
interface sidta_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [sidta_pkg::VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

### design/sidta_out_if.sv
// Output channel of the converter: valid/ready plus one character and its last flag.
// Depends on sidta_pkg.
interface sidta_out_if;
  logic                          valid;
  logic                          ready;
  logic [sidta_pkg::CHAR_W-1:0]  character;
  logic                          last_char;

  modport source (output valid, output character, output last_char, input ready);
  modport sink   (input valid, input character, input last_char, output ready);
endinterface

### design/signed_int_to_decimal_ascii.sv
// Signed 32-bit integer to decimal ASCII text. Each accepted value yields its decimal
// characters on the output channel, most significant first: '-' for a negative value,
// then the digits without leading zeros ("0" for zero), with last_char set on the final
// one. The magnitude is converted by a bit-serial shift-and-add-3 unit, one input bit per
// cycle, and then the characters (1 to 11) are loaded into the output register one after
// another as the output side takes them; the input is ready again once the last character
// sits in the output register.
// Depends on sidta_pkg, sidta_in_if, sidta_out_if and sidta_dabble.
module signed_int_to_decimal_ascii (
  input  logic               clk_i,
  input  logic               rst_ni,
  sidta_in_if.sink           in_i,
  sidta_out_if.source        out_o
);
  import sidta_pkg::*;

  state_e               state_q, state_d;
  logic                 neg_q;
  logic [DIG_IDX_W-1:0] idx_q;
  logic                 out_valid_q;
  logic [CHAR_W-1:0]    out_char_q, out_char_d;
  logic                 out_last_q, out_last_d;

  logic                 in_ready;
  logic                 in_fire;
  logic                 slot_free;
  logic                 load;
  logic                 start;
  logic [VALUE_W-1:0]   raw;
  logic [VALUE_W-1:0]   mag;
  logic [3:0]           digit;
  dd_res_t              res;

  assign in_fire   = in_i.valid && in_ready;
  assign slot_free = !out_valid_q || out_o.ready;
  assign raw       = VALUE_W'(unsigned'(in_i.value));
  assign mag       = raw[VALUE_W-1] ? (VALUE_W'(0) - raw) : raw;
  assign digit     = res.bcd[{idx_q, 2'b00} +: 4];

  sidta_dabble u_dabble (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .mag_i   (mag),
    .res_o   (res)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_fire) state_d = ST_CONV;
      ST_CONV:  if (res.done) state_d = neg_q ? ST_SIGN : ST_DIGIT;
      ST_SIGN:  if (slot_free) state_d = ST_DIGIT;
      ST_DIGIT: if (slot_free && idx_q == '0) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs of the FSM
  always_comb begin
    in_ready   = 1'b0;
    start      = 1'b0;
    load       = 1'b0;
    out_char_d = out_char_q;
    out_last_d = out_last_q;
    case (state_q)
      ST_IDLE: begin
        in_ready = 1'b1;
        start    = in_i.valid;
      end
      ST_CONV: begin
      end
      ST_SIGN: begin
        load       = slot_free;
        out_char_d = CH_MINUS;
        out_last_d = 1'b0;
      end
      ST_DIGIT: begin
        load       = slot_free;
        out_char_d = CH_ZERO + {4'b0000, digit};
        out_last_d = (idx_q == '0);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      neg_q <= raw[VALUE_W-1];
    end
    if (state_q == ST_CONV && res.done) begin
      idx_q <= res.lead;
    end else if (state_q == ST_DIGIT && load && idx_q != '0) begin
      idx_q <= idx_q - 1'b1;
    end
    if (load) begin
      out_char_q <= out_char_d;
      out_last_q <= out_last_d;
    end
  end

  assign in_i.ready      = in_ready;
  assign out_o.valid     = out_valid_q;
  assign out_o.character = out_char_q;
  assign out_o.last_char = out_last_q;

  a_done_in_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.done |-> state_q == ST_CONV)
    else $error("converter finished outside the conversion state");

  a_sign_only_neg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SIGN |-> neg_q)
    else $error("sign emitted for a non-negative value");

  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_char_q == CH_MINUS |-> !out_last_q)
    else $error("minus sign flagged as last character");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIGIT |-> idx_q <= DIG_IDX_W'(NDIGITS - 1))
    else $error("digit index out of range");

endmodule

### design/sidta_dabble.sv
// Bit-serial binary to BCD converter (shift and add-3), one input bit per cycle.
// Depends on sidta_pkg.
module sidta_dabble (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [sidta_pkg::VALUE_W-1:0]      mag_i,
  output sidta_pkg::dd_res_t                 res_o
);
  import sidta_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [BIT_CNT_W-1:0] cnt_q, cnt_d;
  logic [VALUE_W-1:0]   bin_q, bin_d;
  logic [BCD_W-1:0]     bcd_q, bcd_d;
  logic [BCD_W-1:0]     adj;
  logic [DIG_IDX_W-1:0] lead;

  // add 3 to every digit that is 5 or more before the shift
  always_comb begin
    for (int i = 0; i < NDIGITS; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      bin_d  = mag_i;
      bcd_d  = '0;
    end else if (busy_q) begin
      bcd_d = {adj[BCD_W-2:0], bin_q[VALUE_W-1]};
      bin_d = {bin_q[VALUE_W-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == BIT_CNT_W'(VALUE_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_comb begin
    lead = '0;
    for (int i = 0; i < NDIGITS; i++) begin
      if (bcd_q[4*i +: 4] != 4'd0) begin
        lead = DIG_IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign res_o.done = done_q;
  assign res_o.lead = lead;
  assign res_o.bcd  = bcd_q;

  a_done_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("done raised while still shifting");

  a_done_after_last_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q) && $past(cnt_q) == BIT_CNT_W'(VALUE_W - 1))
    else $error("done without a full pass over the input bits");

  a_no_restart_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !start_i |=> busy_q || done_q)
    else $error("conversion stopped early");

endmodule

### sim/tb.sv
// Testbench for signed_int_to_decimal_ascii: drives signed values, looks up or predicts the
// decimal text of each one and checks every character and last flag as it leaves the block.
// Depends on sidta_pkg, sidta_in_if, sidta_out_if and the converter RTL.
`timescale 1ns / 100ps

module tb;
  import sidta_pkg::*;

  localparam int unsigned NUM_DIRECTED = 20;
  localparam int unsigned NUM_RANDOM   = 450;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned TAIL_CYCLES  = 60;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } char_exp_t;

  logic clk_i;
  logic rst_ni;

  sidta_in_if  in_if ();
  sidta_out_if out_if ();

  signed_int_to_decimal_ascii u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // text queued by the sender, moved to the character store when the transfer happens
  string       pending_text [$];
  char_exp_t   exp_chars [$];
  int unsigned err_cnt;
  int unsigned cycle_cnt;
  int unsigned burst_left;

  // directed rows: an empty string means the expected text comes from the predictor
  logic [VALUE_W-1:0] dir_value [NUM_DIRECTED] = '{
    32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10,
    32'd2147483647, 32'h8000_0000, -32'sd2147483647,
    32'd1000000000, 32'd999999999, -32'sd1000000000,
    32'd12345, -32'sd987654321, 32'h5555_5555, 32'hAAAA_AAAA,
    32'd100, -32'sd7, 32'd4000000000, 32'd65536
  };
  string dir_text [NUM_DIRECTED] = '{
    "0", "1", "-1", "9", "10", "-10",
    "2147483647", "-2147483648", "-2147483647",
    "1000000000", "999999999", "-1000000000",
    "", "", "", "",
    "", "", "", ""
  };

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // Decimal text of a 32-bit two's complement value, sign first, no leading zeros.
  function automatic string decimal_text(input logic [VALUE_W-1:0] raw);
    logic [VALUE_W-1:0] mag;
    string              txt;
    int unsigned        ndig;
    mag  = raw[VALUE_W-1] ? (~raw + 1'b1) : raw;
    txt  = "";
    ndig = 0;
    do begin
      txt       = {" ", txt};
      txt[0]    = CH_ZERO + 8'(mag % 10);
      mag       = mag / 10;
      ndig++;
    end while (mag != 0 && ndig < NDIGITS);
    if (raw[VALUE_W-1]) begin
      txt    = {" ", txt};
      txt[0] = CH_MINUS;
    end
    return txt;
  endfunction

  task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
    $display("%0t ns mismatch on %s: want %0h, got %0h", $time, what, want, got);
    err_cnt++;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (pending_text.size() != 0 || exp_chars.size() != 0) @(posedge clk_i);
  endtask

  // One input transfer; gaps between bursts of random length.
  task automatic send_value(input logic [VALUE_W-1:0] v, input string txt);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk_i);
        in_if.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 10);
    end
    burst_left--;
    @(negedge clk_i);
    pending_text.push_back(txt);
    in_if.valid <= 1'b1;
    in_if.value <= v;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  function automatic logic [VALUE_W-1:0] random_value();
    logic [VALUE_W-1:0] v;
    logic [VALUE_W-1:0] p;
    int unsigned        k;
    case ($urandom_range(0, 5))
      0: v = $urandom_range(0, 20);
      1: begin
        // around a power of ten
        p = 1;
        k = $urandom_range(0, 9);
        repeat (k) p = p * 10;
        v = p + $urandom_range(0, 2) - 1;
      end
      2: begin
        // random number of digits
        p = 10;
        k = $urandom_range(0, 8);
        repeat (k) p = p * 10;
        v = $urandom % p;
      end
      3: case ($urandom_range(0, 4))
        0: v = 32'h8000_0000;
        1: v = 32'h7FFF_FFFF;
        2: v = 32'h8000_0001;
        3: v = 32'hFFFF_FFFF;
        default: v = '0;
      endcase
      default: v = $urandom;
    endcase
    if ($urandom_range(0, 1) == 1) v = ~v + 1'b1;
    return v;
  endfunction

  // receiver: ready runs of random length broken by stalls, some stretches stall-free
  initial begin
    int unsigned run_len;
    int unsigned stall_len;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      run_len   = $urandom_range(1, 24);
      stall_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (run_len) begin
        @(negedge clk_i);
        out_if.ready <= 1'b1;
      end
      repeat (stall_len) begin
        @(negedge clk_i);
        out_if.ready <= 1'b0;
      end
    end
  end

  // transfer monitor: queue expectations on input, check characters on output
  string     acc_text;
  char_exp_t want_char;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        acc_text = pending_text.pop_front();
        for (int i = 0; i < acc_text.len(); i++) begin
          exp_chars.push_back('{ch: acc_text[i], last: (i == acc_text.len() - 1)});
        end
      end
      if (out_if.valid && out_if.ready) begin
        if (exp_chars.size() == 0) begin
          report("unexpected character", '0, 32'(out_if.character));
        end else begin
          want_char = exp_chars.pop_front();
          if (out_if.character !== want_char.ch)
            report("character", 32'(want_char.ch), 32'(out_if.character));
          if (out_if.last_char !== want_char.last)
            report("last_char", 32'(want_char.last), 32'(out_if.last_char));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    logic [VALUE_W-1:0] v;
    err_cnt     = 0;
    cycle_cnt   = 0;
    burst_left  = 0;
    in_if.valid = 1'b0;
    in_if.value = '0;
    @(posedge rst_ni);
    @(negedge clk_i);

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_value(dir_value[i],
                 (dir_text[i] == "") ? decimal_text(dir_value[i]) : dir_text[i]);
    end
    wait_drained();

    for (int n = 0; n < NUM_RANDOM; n++) begin
      v = random_value();
      send_value(v, decimal_text(v));
      if (n == 150 || n == 300) wait_drained();
    end
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
